// ----- sv/flock_separation_force_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for flock_separation_force_core
// Concurrent checks on clock, quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef FLOCK_SEPARATION_FORCE_CORE_ASSERT_SVH
`define FLOCK_SEPARATION_FORCE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FSF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define FSF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FSF_ASSERT_NOW(lbl, ante, cons, msg)
`define FSF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/fsf_pkg.sv -----
// ----------------------------------------------------------------------------
// fsf_pkg
// Types and constants shared by the separation force controller and datapath.
// ----------------------------------------------------------------------------
package fsf_pkg;

   localparam int MAX_AGENTS  = 64;
   localparam int AGENT_AW    = $clog2(MAX_AGENTS);
   localparam int COUNT_W     = 7;
   localparam int PUSH_W      = 20;
   localparam int PUSH_LIMIT  = 262144;
   localparam int FRAC_W      = 12;
   localparam int ROOT_STEPS  = 17;
   localparam int DIV_STEPS   = FRAC_W;
   localparam int STEP_W      = $clog2(ROOT_STEPS);
   localparam int SUM_W       = PUSH_W + $clog2(MAX_AGENTS) + 1;
   localparam logic [15:0] RADIUS_RESET = 16'd3200;

   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_REMOVE  = 2'd1;
   localparam logic [1:0] ACT_QUERY   = 2'd2;
   localparam logic [1:0] ACT_IGNORED = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [5:0]         agent_slot;
      logic               exclude_self;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
   } req_type;

   typedef struct packed {
      logic signed [PUSH_W-1:0] push_x;
      logic signed [PUSH_W-1:0] push_y;
      logic [COUNT_W-1:0]       neighbor_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIFF,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_PROD,
      ST_DIV,
      ST_ACC,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                accept;
      logic                fetch;
      logic                diff;
      logic                square;
      logic                sum;
      logic                root;
      logic                prod;
      logic                div;
      logic                acc;
      logic                load_out;
      logic [AGENT_AW-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic query_go;
      logic diff_skip;
      logic sum_skip;
      logic out_free;
   } dp_status_type;

endpackage

// ----- sv/fsf_controller.sv -----
// ----------------------------------------------------------------------------
// fsf_controller
// Sequencer: walks the agent table per query and steps root and divide units.
// ----------------------------------------------------------------------------
`include "flock_separation_force_core_assert.svh"

module fsf_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fsf_pkg::dp_status_type status,
   output fsf_pkg::dp_cmd_type    cmd
);

   fsf_pkg::state_type              state_ff, state_in;
   logic [fsf_pkg::AGENT_AW-1:0]    idx_ff, idx_in;
   logic [fsf_pkg::STEP_W-1:0]      step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsf_pkg::ST_IDLE;
         idx_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      step_in   = step_ff;
      req_stall = 1'b1;
      cmd       = '0;
      cmd.idx   = idx_ff;
      case (state_ff)
         fsf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               idx_in     = '0;
               state_in   = status.query_go ? fsf_pkg::ST_FETCH : fsf_pkg::ST_DONE;
            end
         end
         fsf_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = fsf_pkg::ST_DIFF;
         end
         fsf_pkg::ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = status.diff_skip ? fsf_pkg::ST_NEXT : fsf_pkg::ST_SQUARE;
         end
         fsf_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = fsf_pkg::ST_SUM;
         end
         fsf_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            step_in  = '0;
            state_in = status.sum_skip ? fsf_pkg::ST_NEXT : fsf_pkg::ST_ROOT;
         end
         fsf_pkg::ST_ROOT: begin
            cmd.root = 1'b1;
            if (step_ff == fsf_pkg::STEP_W'(fsf_pkg::ROOT_STEPS - 1)) begin
               step_in  = '0;
               state_in = fsf_pkg::ST_PROD;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         fsf_pkg::ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = fsf_pkg::ST_DIV;
         end
         fsf_pkg::ST_DIV: begin
            cmd.div = 1'b1;
            if (step_ff == fsf_pkg::STEP_W'(fsf_pkg::DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = fsf_pkg::ST_ACC;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         fsf_pkg::ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = fsf_pkg::ST_NEXT;
         end
         fsf_pkg::ST_NEXT: begin
            if (idx_ff == fsf_pkg::AGENT_AW'(fsf_pkg::MAX_AGENTS - 1)) begin
               state_in = fsf_pkg::ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = fsf_pkg::ST_FETCH;
            end
         end
         fsf_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = fsf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fsf_pkg::ST_IDLE;
         end
      endcase
   end

   `FSF_ASSERT_NXT(a_accept_leaves_idle, req_valid && !req_stall,
      state_ff != fsf_pkg::ST_IDLE, "accepted transfer did not start work")
   `FSF_ASSERT_NOW(a_root_steps, state_ff == fsf_pkg::ST_ROOT,
      step_ff < fsf_pkg::STEP_W'(fsf_pkg::ROOT_STEPS), "root step out of range")
   `FSF_ASSERT_NOW(a_div_steps, state_ff == fsf_pkg::ST_DIV,
      step_ff < fsf_pkg::STEP_W'(fsf_pkg::DIV_STEPS), "divide step out of range")

endmodule

// ----- sv/fsf_datapath.sv -----
// ----------------------------------------------------------------------------
// fsf_datapath
// Agent table, distance, square root, divide and push accumulation.
// ----------------------------------------------------------------------------
`include "flock_separation_force_core_assert.svh"

module fsf_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  fsf_pkg::dp_cmd_type    cmd,
   output fsf_pkg::dp_status_type status,
   input  fsf_pkg::req_type       req_data,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fsf_pkg::rsp_type       rsp_data
);

   localparam int SW = fsf_pkg::SUM_W;
   localparam int CW = fsf_pkg::COUNT_W;

   logic [23:0] agent_x_mem [fsf_pkg::MAX_AGENTS];
   logic [23:0] agent_y_mem [fsf_pkg::MAX_AGENTS];

   logic [15:0]                     radius_ff;
   logic [fsf_pkg::MAX_AGENTS-1:0]  valid_ff;
   logic [fsf_pkg::AGENT_AW:0]      vcount_ff;
   logic [23:0]                     rd_x_ff, rd_y_ff;
   logic                            rd_valid_ff;
   logic [23:0]                     qx_ff, qy_ff;
   logic [fsf_pkg::AGENT_AW-1:0]    slot_ff;
   logic                            excl_ff, slot_ok_ff;
   logic [31:0]                     rsq_ff;
   logic [15:0]                     absx_ff, absy_ff;
   logic                            negx_ff, negy_ff;
   logic [31:0]                     sqx_ff, sqy_ff;
   logic [33:0]                     vsh_ff;
   logic [19:0]                     rem_ff;
   logic [16:0]                     root_ff;
   logic [31:0]                     remx_ff, remy_ff, den_ff;
   logic [fsf_pkg::FRAC_W-1:0]      quox_ff, quoy_ff;
   logic signed [SW-1:0]            sumx_ff, sumy_ff;
   logic [CW-1:0]                   count_ff;
   logic                            rsp_valid_ff;
   fsf_pkg::rsp_type                rsp_ff;

   logic [fsf_pkg::AGENT_AW-1:0]    wslot;
   logic                            wslot_ok;
   logic [24:0]                     dx, dy, adx, ady;
   logic [32:0]                     dsq;
   logic [19:0]                     rem_sh, trial;
   logic [15:0]                     root_d, rmd;
   logic [32:0]                     tx, ty;
   logic signed [SW-1:0]            termx, termy;
   logic signed [SW-1:0]            push_max;

   assign wslot    = fsf_pkg::AGENT_AW'(req_data.agent_slot);
   assign wslot_ok = ({1'b0, req_data.agent_slot} < 7'(fsf_pkg::MAX_AGENTS));
   assign push_max = SW'(fsf_pkg::PUSH_LIMIT);

   // table writes at accept, one read per fetch
   always_ff @(posedge clock) begin
      if (cmd.accept && req_data.action == fsf_pkg::ACT_WRITE && wslot_ok) begin
         agent_x_mem[wslot] <= req_data.pos_x;
         agent_y_mem[wslot] <= req_data.pos_y;
      end
      if (cmd.fetch) begin
         rd_x_ff <= agent_x_mem[cmd.idx];
         rd_y_ff <= agent_y_mem[cmd.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= fsf_pkg::RADIUS_RESET;
         valid_ff     <= '0;
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) radius_ff <= csr_wr_data;
         if (cmd.accept && wslot_ok) begin
            if (req_data.action == fsf_pkg::ACT_WRITE && !valid_ff[wslot]) begin
               valid_ff[wslot] <= 1'b1;
               vcount_ff       <= vcount_ff + 1'b1;
            end else if (req_data.action == fsf_pkg::ACT_REMOVE && valid_ff[wslot]) begin
               valid_ff[wslot] <= 1'b0;
               vcount_ff       <= vcount_ff - 1'b1;
            end
         end
         if (cmd.load_out) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      dx  = {qx_ff[23], qx_ff} - {rd_x_ff[23], rd_x_ff};
      dy  = {qy_ff[23], qy_ff} - {rd_y_ff[23], rd_y_ff};
      adx = dx[24] ? -dx : dx;
      ady = dy[24] ? -dy : dy;
      dsq = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      rem_sh = {rem_ff[17:0], vsh_ff[33:32]};
      trial  = {1'b0, root_ff, 2'b01};
      root_d = root_ff[15:0];
      rmd    = radius_ff - root_d;
      tx     = {remx_ff, 1'b0};
      ty     = {remy_ff, 1'b0};
      termx  = negx_ff ? -SW'(quox_ff) : SW'(quox_ff);
      termy  = negy_ff ? -SW'(quoy_ff) : SW'(quoy_ff);
   end

   always_comb begin
      status.query_go  = (req_data.action == fsf_pkg::ACT_QUERY) && (radius_ff != 16'd0) &&
                         (vcount_ff >= (fsf_pkg::AGENT_AW + 1)'(2));
      // abs diff at or above radius already puts dsq at or above radius squared
      status.diff_skip = !rd_valid_ff || (excl_ff && slot_ok_ff && slot_ff == cmd.idx) ||
                         (adx >= {9'd0, radius_ff}) || (ady >= {9'd0, radius_ff});
      status.sum_skip  = (dsq == 33'd0) || (dsq >= {1'b0, rsq_ff});
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         qx_ff      <= req_data.pos_x;
         qy_ff      <= req_data.pos_y;
         slot_ff    <= wslot;
         slot_ok_ff <= wslot_ok;
         excl_ff    <= req_data.exclude_self;
         rsq_ff     <= 32'(radius_ff) * 32'(radius_ff);
         sumx_ff    <= '0;
         sumy_ff    <= '0;
         count_ff   <= '0;
      end
      if (cmd.fetch) rd_valid_ff <= valid_ff[cmd.idx];
      if (cmd.diff) begin
         absx_ff <= adx[15:0];
         absy_ff <= ady[15:0];
         negx_ff <= dx[24];
         negy_ff <= dy[24];
      end
      if (cmd.square) begin
         sqx_ff <= 32'(absx_ff) * 32'(absx_ff);
         sqy_ff <= 32'(absy_ff) * 32'(absy_ff);
      end
      if (cmd.sum) begin
         vsh_ff  <= {1'b0, dsq};
         rem_ff  <= '0;
         root_ff <= '0;
      end
      // one result bit of the square root per step
      if (cmd.root) begin
         vsh_ff <= {vsh_ff[31:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[15:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[15:0], 1'b0};
         end
      end
      if (cmd.prod) begin
         remx_ff <= 32'(absx_ff) * 32'(rmd);
         remy_ff <= 32'(absy_ff) * 32'(rmd);
         den_ff  <= 32'(root_d) * 32'(radius_ff);
      end
      // restoring divide, one quotient bit per step
      if (cmd.div) begin
         if (tx >= {1'b0, den_ff}) begin
            remx_ff <= 32'(tx - {1'b0, den_ff});
            quox_ff <= {quox_ff[fsf_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            remx_ff <= tx[31:0];
            quox_ff <= {quox_ff[fsf_pkg::FRAC_W-2:0], 1'b0};
         end
         if (ty >= {1'b0, den_ff}) begin
            remy_ff <= 32'(ty - {1'b0, den_ff});
            quoy_ff <= {quoy_ff[fsf_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            remy_ff <= ty[31:0];
            quoy_ff <= {quoy_ff[fsf_pkg::FRAC_W-2:0], 1'b0};
         end
      end
      if (cmd.acc) begin
         sumx_ff <= sumx_ff + termx;
         sumy_ff <= sumy_ff + termy;
         if (count_ff != {CW{1'b1}}) count_ff <= count_ff + 1'b1;
      end
      if (cmd.load_out) begin
         if (sumx_ff > push_max)       rsp_ff.push_x <= fsf_pkg::PUSH_W'(fsf_pkg::PUSH_LIMIT);
         else if (sumx_ff < -push_max) rsp_ff.push_x <= -fsf_pkg::PUSH_W'(fsf_pkg::PUSH_LIMIT);
         else                          rsp_ff.push_x <= sumx_ff[fsf_pkg::PUSH_W-1:0];
         if (sumy_ff > push_max)       rsp_ff.push_y <= fsf_pkg::PUSH_W'(fsf_pkg::PUSH_LIMIT);
         else if (sumy_ff < -push_max) rsp_ff.push_y <= -fsf_pkg::PUSH_W'(fsf_pkg::PUSH_LIMIT);
         else                          rsp_ff.push_y <= sumy_ff[fsf_pkg::PUSH_W-1:0];
         rsp_ff.neighbor_count <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `FSF_ASSERT_NOW(a_valid_count, 1'b1,
      $countones(valid_ff) == 32'(vcount_ff), "valid count out of step with valid marks")
   `FSF_ASSERT_NOW(a_root_below_radius, cmd.prod,
      root_ff < {1'b0, radius_ff}, "distance not below radius")
   `FSF_ASSERT_NOW(a_den_nonzero, cmd.div, den_ff != 32'd0, "divide by zero distance")

endmodule

// ----- sv/flock_separation_force_core.sv -----
// ----------------------------------------------------------------------------
// flock_separation_force_core
// Agent position table with a brute-force separation push query.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | fsf_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall | fsf_pkg::rsp_type
//  csr     | in        | csr_wr_en           | csr_wr_data (radius)
//
//  Write and remove go from accept straight to the done state, which loads the result.
//  A query with nonzero radius and two or more valid agents visits all 64 slots one by
//  one: a slot skipped early passes fetch, diff and next; one out of range also square
//  and sum; a contributor also the 17-step square root, product, 12-step divide and acc.
//  Reset is synchronous and clears all valid marks at once; radius returns to 3200.
//  A stalled result holds in the output register; the next transfer is taken meanwhile.
// ----------------------------------------------------------------------------
module flock_separation_force_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fsf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fsf_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data
);

   fsf_pkg::dp_cmd_type    cmd;
   fsf_pkg::dp_status_type status;

   fsf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fsf_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Separation push testbench
// Drives writes, removes and queries into the agent table, predicts every
// push from a software copy of the table and radius, and checks each result
// in order. Covers idle and stall patterns, back pressure and radius changes.
// ----------------------------------------------------------------------------

class push_scoreboard;
   logic signed [23:0] pos_x_tab [64];
   logic signed [23:0] pos_y_tab [64];
   bit                 live [64];
   logic [15:0]        radius;
   fsf_pkg::rsp_type   pending [$];
   int                 errors;

   function new();
      radius = fsf_pkg::RADIUS_RESET;
      foreach (live[i]) begin
         live[i] = 0;
         pos_x_tab[i] = '0;
         pos_y_tab[i] = '0;
      end
      errors = 0;
   endfunction

   function longint root_floor(longint v);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function longint term(longint diff, longint d, longint r);
      longint mag;
      longint q;
      mag = (diff < 0) ? -diff : diff;
      q = (mag * (r - d) * 4096) / (d * r);
      return (diff < 0) ? -q : q;
   endfunction

   function void note_request(fsf_pkg::req_type rq);
      fsf_pkg::rsp_type res;
      longint sx, sy, dx, dy, dsq, d, r;
      int nvalid, cnt;
      sx = 0;
      sy = 0;
      cnt = 0;
      nvalid = 0;
      r = radius;
      if (rq.action == fsf_pkg::ACT_WRITE) begin
         pos_x_tab[rq.agent_slot] = rq.pos_x;
         pos_y_tab[rq.agent_slot] = rq.pos_y;
         live[rq.agent_slot] = 1;
      end else if (rq.action == fsf_pkg::ACT_REMOVE) begin
         live[rq.agent_slot] = 0;
      end else if (rq.action == fsf_pkg::ACT_QUERY && radius != 0) begin
         foreach (live[i]) if (live[i]) nvalid++;
         if (nvalid >= 2) begin
            for (int i = 0; i < 64; i++) begin
               if (!live[i] || (rq.exclude_self && i == rq.agent_slot)) continue;
               dx = longint'(rq.pos_x) - longint'(pos_x_tab[i]);
               dy = longint'(rq.pos_y) - longint'(pos_y_tab[i]);
               dsq = dx * dx + dy * dy;
               if (dsq == 0 || dsq >= r * r) continue;
               d = root_floor(dsq);
               sx += term(dx, d, r);
               sy += term(dy, d, r);
               cnt++;
            end
         end
      end
      if (sx > fsf_pkg::PUSH_LIMIT) sx = fsf_pkg::PUSH_LIMIT;
      if (sx < -fsf_pkg::PUSH_LIMIT) sx = -fsf_pkg::PUSH_LIMIT;
      if (sy > fsf_pkg::PUSH_LIMIT) sy = fsf_pkg::PUSH_LIMIT;
      if (sy < -fsf_pkg::PUSH_LIMIT) sy = -fsf_pkg::PUSH_LIMIT;
      res.push_x = sx[19:0];
      res.push_y = sy[19:0];
      res.neighbor_count = cnt[6:0];
      pending.push_back(res);
   endfunction

   task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task check_result(fsf_pkg::rsp_type got);
      fsf_pkg::rsp_type want;
      if (pending.size() == 0) begin
         report("unexpected transfer", 0, 0);
         return;
      end
      want = pending.pop_front();
      if (got.push_x !== want.push_x) report("push_x", got.push_x, want.push_x);
      if (got.push_y !== want.push_y) report("push_y", got.push_y, want.push_y);
      if (got.neighbor_count !== want.neighbor_count)
         report("neighbor_count", got.neighbor_count, want.neighbor_count);
   endtask
endclass

module tb;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   fsf_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 0;
   fsf_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 0;
   logic [15:0]      csr_wr_data = '0;

   int  send_idle = 0;
   int  recv_idle = 0;
   bit  hold_rsp = 0;
   push_scoreboard board;

   flock_separation_force_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // receiver: random stall, plus a long hold when asked
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle);
   end

   // valid stays up after a transfer; drain drops it, the next send drops it only while idling
   task send(fsf_pkg::req_type rq);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(rq);
   endtask

   task drain();
      int guard;
      guard = 0;
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      while (guard < 3000) begin
         guard++;
         @(posedge clock);
      end
   endtask

   task set_radius(logic [15:0] r);
      csr_wr_en   <= 1;
      csr_wr_data <= r;
      @(posedge clock);
      csr_wr_en   <= 0;
      board.radius = r;
   endtask

   function automatic fsf_pkg::req_type make(logic [1:0] act, int slot, bit ex,
                                             int x, int y);
      fsf_pkg::req_type rq;
      rq.action = act;
      rq.agent_slot = slot[5:0];
      rq.exclude_self = ex;
      rq.pos_x = x[23:0];
      rq.pos_y = y[23:0];
      return rq;
   endfunction

   // cluster around a center so neighbors fall inside the radius
   function automatic fsf_pkg::req_type rand_item(int cx, int cy, int spread);
      int pick;
      int x, y;
      fsf_pkg::req_type rq;
      pick = $urandom_range(99);
      x = cx + $signed($urandom_range(2 * spread)) - spread;
      y = cy + $signed($urandom_range(2 * spread)) - spread;
      if (pick < 5) begin
         rq = fsf_pkg::req_type'(($bits(fsf_pkg::req_type))'({$urandom, $urandom}));
         return rq;
      end
      if (pick < 45)
         return make(fsf_pkg::ACT_WRITE, $urandom_range(63), $urandom_range(1), x, y);
      if (pick < 55)
         return make(fsf_pkg::ACT_REMOVE, $urandom_range(63), $urandom_range(1), x, y);
      if (pick < 58)
         return make(fsf_pkg::ACT_IGNORED, $urandom_range(63), $urandom_range(1), x, y);
      return make(fsf_pkg::ACT_QUERY, $urandom_range(63), $urandom_range(1), x, y);
   endfunction

   task random_phase(int n, int spread);
      int cx, cy;
      cx = $signed($urandom_range(16000000)) - 8000000;
      cy = $signed($urandom_range(16000000)) - 8000000;
      for (int i = 0; i < n; i++) send(rand_item(cx, cy, spread));
   endtask

   initial begin
      #200000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty table, single agent, extremes, exact hit, exclusion
      send(make(fsf_pkg::ACT_QUERY, 0, 0, 0, 0));
      send(make(fsf_pkg::ACT_WRITE, 0, 0, 100, 100));
      send(make(fsf_pkg::ACT_QUERY, 0, 0, 100, 100));
      send(make(fsf_pkg::ACT_WRITE, 1, 1, 150, 60));
      send(make(fsf_pkg::ACT_WRITE, 1, 0, 140, 90));
      send(make(fsf_pkg::ACT_QUERY, 0, 0, 100, 100));
      send(make(fsf_pkg::ACT_QUERY, 0, 1, 100, 100));
      send(make(fsf_pkg::ACT_QUERY, 63, 1, 120, 95));
      send(make(fsf_pkg::ACT_WRITE, 62, 0, -8388608, 8388607));
      send(make(fsf_pkg::ACT_WRITE, 63, 1, 8388607, -8388608));
      send(make(fsf_pkg::ACT_QUERY, 62, 0, -8388600, 8388600));
      send(make(fsf_pkg::ACT_QUERY, 5, 1, 8388607, 8388607));
      send(make(fsf_pkg::ACT_IGNORED, 7, 1, 1, 1));
      send(make(fsf_pkg::ACT_REMOVE, 40, 0, 0, 0));
      send(make(fsf_pkg::ACT_REMOVE, 1, 0, 0, 0));
      send(make(fsf_pkg::ACT_QUERY, 0, 0, 110, 110));
      for (int i = 2; i < 8; i++)
         send(make(fsf_pkg::ACT_WRITE, i, 0, 100 + i * 7, 100 - i * 5));
      send(make(fsf_pkg::ACT_QUERY, 3, 1, 101, 99));
      drain();

      set_radius(16'd0);
      send(make(fsf_pkg::ACT_QUERY, 0, 0, 100, 100));
      drain();
      set_radius(16'hFFFF);
      send(make(fsf_pkg::ACT_QUERY, 0, 0, -30000, 30000));
      drain();
      set_radius(16'd1);
      send(make(fsf_pkg::ACT_QUERY, 0, 0, 101, 100));
      drain();
      set_radius(16'd2);
      send(make(fsf_pkg::ACT_QUERY, 0, 0, 101, 100));
      drain();

      send_idle = 33;
      recv_idle = 49;
      set_radius(16'd3200);
      random_phase(400, 2000);
      drain();
      send_idle = 49;
      recv_idle = 33;
      set_radius(16'd600);
      random_phase(400, 500);
      drain();
      send_idle = 0;
      recv_idle = 0;
      set_radius(16'hFFFF);
      random_phase(400, 20000);

      // hold the receiver so the block backs up onto its input
      fork
         begin
            hold_rsp = 1;
            for (int c = 0; c < 400; c++) @(posedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 6; i++) send(make(fsf_pkg::ACT_WRITE, i + 20, 0, i, i));
      join
      drain();
      set_radius(16'd40);
      random_phase(400, 40);
      drain();
      set_radius(16'd9000);
      send_idle = 10;
      recv_idle = 10;
      random_phase(400, 6000);
      drain();

      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
